// File: hw/rtl/rbsd_pkg.sv
// Shared types and constants for the run-length byte stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package rbsd_pkg;

    // Decoder phase codes
    localparam logic [2:0] PH_LEN_LO  = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_CONTROL = 3'd2;
    localparam logic [2:0] PH_REPEAT  = 3'd3;
    localparam logic [2:0] PH_LITERAL = 3'd4;

    // Control byte fields
    localparam logic [7:0] TOP_BIT   = 8'h80;
    localparam logic [7:0] LOW7_MASK = 8'h7f;

    // Widths of the decoder state
    localparam int LEN_W = 16;
    localparam int POS_W = 17;
    localparam int RUN_W = 8;

    // One decoded result as produced by the core
    typedef struct packed {
        logic       valid;
        logic [7:0] value;
        logic [7:0] copies;
        logic       image_done;
    } rbsd_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/rbsd_in_stage.sv
// Input register for compressed bytes, full throughput while the held byte is consumed.
`timescale 1ns / 1ps
`default_nettype none

module rbsd_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       consume,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);
    import rbsd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // Room when empty or when the held byte leaves this cycle
    assign s_tready = !valid_reg || consume;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rbsd_core.sv
// Decoder state and per-byte next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none

module rbsd_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step,
    input  wire logic [7:0]          in_byte,
    output rbsd_pkg::rbsd_result_t   result
);
    import rbsd_pkg::*;

    logic [2:0]       phase_reg,  phase_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [POS_W-1:0] pos_reg,    pos_next;
    logic [RUN_W-1:0] run_reg,    run_next;

    logic [POS_W-1:0] length_ext;
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] run_ext;
    logic [POS_W-1:0] pos_sum;
    logic [POS_W-1:0] pos_inc;
    logic [RUN_W-1:0] run_dec;
    logic [7:0]       clip_copies;

    assign length_ext = {1'b0, length_reg};
    assign run_ext    = {{(POS_W-RUN_W){1'b0}}, run_reg};
    assign left       = (pos_reg < length_ext) ? (length_ext - pos_reg) : '0;
    assign pos_sum    = pos_reg + run_ext;
    assign pos_inc    = pos_reg + {{(POS_W-1){1'b0}}, 1'b1};
    assign run_dec    = run_reg - 8'd1;
    // Repeat count clipped at the remaining length
    assign clip_copies = (run_ext < left) ? run_reg : left[7:0];

    // Per-byte decode
    always_comb begin
        phase_next  = phase_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        run_next    = run_reg;
        result      = '0;
        case (phase_reg)
            PH_LEN_HI: begin
                length_next = {in_byte, length_reg[7:0]};
                pos_next    = '0;
                run_next    = '0;
                phase_next  = PH_CONTROL;
            end
            PH_CONTROL: begin
                if ((in_byte & TOP_BIT) != 8'h00) begin
                    run_next   = (in_byte & LOW7_MASK) + 8'd1;
                    phase_next = PH_REPEAT;
                end else if (pos_reg >= length_ext) begin
                    // Literal control with nothing left: finish empty
                    result      = '{valid: 1'b1, value: 8'h00, copies: 8'h00,
                                    image_done: 1'b1};
                    phase_next  = PH_LEN_LO;
                    length_next = '0;
                    pos_next    = '0;
                    run_next    = '0;
                end else begin
                    run_next   = in_byte + 8'd1;
                    phase_next = PH_LITERAL;
                end
            end
            PH_REPEAT: begin
                result.valid  = 1'b1;
                result.value  = in_byte;
                result.copies = clip_copies;
                if (pos_sum > length_ext) begin
                    result.image_done = 1'b1;
                    phase_next  = PH_LEN_LO;
                    length_next = '0;
                    pos_next    = '0;
                    run_next    = '0;
                end else begin
                    pos_next   = pos_sum;
                    run_next   = '0;
                    phase_next = PH_CONTROL;
                end
            end
            PH_LITERAL: begin
                result.valid  = 1'b1;
                result.value  = in_byte;
                result.copies = 8'd1;
                if (run_dec == '0) begin
                    pos_next   = pos_inc;
                    run_next   = '0;
                    phase_next = PH_CONTROL;
                end else if (pos_inc >= length_ext) begin
                    // Length reached inside the run: drop the rest
                    result.image_done = 1'b1;
                    phase_next  = PH_LEN_LO;
                    length_next = '0;
                    pos_next    = '0;
                    run_next    = '0;
                end else begin
                    pos_next = pos_inc;
                    run_next = run_dec;
                end
            end
            default: begin
                // Low length byte, also for unused codes
                length_next = {8'h00, in_byte};
                pos_next    = '0;
                run_next    = '0;
                phase_next  = PH_LEN_HI;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LEN_LO;
            length_reg <= '0;
            pos_reg    <= '0;
            run_reg    <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
            run_reg    <= run_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rbsd_out_stage.sv
// Result register driving the output stream.
`timescale 1ns / 1ps
`default_nettype none

module rbsd_out_stage (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  load,
    input  wire rbsd_pkg::rbsd_result_t result,
    output logic                       free,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,
    output logic                       m_tlast
);
    import rbsd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] value_reg;
    logic [7:0] copies_reg;
    logic       done_reg;

    // Register can take a new result when empty or being drained
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg && !m_tready;
        if (load) begin
            valid_next = result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && result.valid) begin
            value_reg  <= result.value;
            copies_reg <= result.copies;
            done_reg   <= result.image_done;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {copies_reg, value_reg};
    assign m_tlast  = done_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rle_byte_stream_decoder_unit.sv
// Top level of the run-length byte stream decoder.
//
//  port group | dir | payload                              | request when
//  s_*        | in  | tdata[7:0] in_byte                   | s_tvalid && s_tready
//  m_*        | out | tdata[7:0] value, [15:8] copies,     | m_tvalid && m_tready
//             |     | tlast image_done                     |
//
// One compressed byte per cycle while the output is not stalled; a result reaches
// the output through the input register, then decode into the result register.
// Header and control bytes produce no result and do not occupy the output, bar a
// literal control byte with nothing left, which gives an empty image_done result.
// A stalled output holds every byte in the input register, header and control bytes
// too; the input register keeps one byte buffered meanwhile. Synchronous active-low
// reset clears the valids and returns the decoder to expecting the low length byte.
`timescale 1ns / 1ps
`default_nettype none

module rle_byte_stream_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] value, [15:8] copies
    output logic             m_tlast    // image_done
);
    import rbsd_pkg::*;

    logic         byte_valid;
    logic [7:0]   byte_data;
    logic         out_free;
    logic         step;
    rbsd_result_t result;

    // Decode the held byte whenever the result register can take its result
    assign step = byte_valid && out_free;

    rbsd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .consume    (step),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    rbsd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_byte (byte_data),
        .result  (result)
    );

    rbsd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Copies never exceed one full repeat run
    a_copies_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:8] <= 8'd128))
        else $error("copies out of range");

    // An empty result only ever finishes an image
    a_zero_copies_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[15:8] == 8'd0)) |-> m_tlast)
        else $error("zero copies without image_done");

    // A held byte that cannot be decoded stays put
    a_byte_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_valid && !step) |=> (byte_valid && $stable(byte_data)))
        else $error("input byte lost while output stalled");

endmodule

`default_nettype wire
